// ----- design/wfdc_pkg.sv -----
// Shared types, register codes and fixed widths of the wall-follow drive controller.
`default_nettype none

package wfdc_pkg;

  localparam int GAIN_W     = 12;
  localparam int PWM_W      = 10;
  localparam int TURN_W     = 9;
  localparam int LVL_OUT_W  = 10;
  localparam int CALIB_W    = 18;
  localparam int COUNT_W    = 8;
  localparam int DRV_W      = 12;
  localparam int TURN_FRAC  = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_DATA_W = 56;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t IDX_GAIN     = 3'd0;
  localparam cfg_idx_t IDX_FORWARD  = 3'd1;
  localparam cfg_idx_t IDX_BACKWARD = 3'd2;
  localparam cfg_idx_t IDX_STOP     = 3'd3;
  localparam cfg_idx_t IDX_TURN_CAP = 3'd4;

  localparam logic [GAIN_W-1:0] GAIN_RST     = 12'd1229;
  localparam logic [PWM_W-1:0]  FORWARD_RST  = 10'd475;
  localparam logic [PWM_W-1:0]  BACKWARD_RST = 10'd325;
  localparam logic [PWM_W-1:0]  STOP_RST     = 10'd400;
  localparam logic [TURN_W-1:0] TURN_CAP_RST = 9'd7;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_q12;
    logic [PWM_W-1:0]  cmp_fwd;
    logic [PWM_W-1:0]  cmp_bwd;
    logic [PWM_W-1:0]  cmp_halt;
    logic [TURN_W-1:0] turn_cap;
  } cfg_t;

  typedef struct packed {
    logic               stopped;
    logic               last;
    logic [CALIB_W-1:0] sum;
  } calib_info_t;

endpackage

`default_nettype wire

// ----- design/wall_follow_drive_controller.sv -----
// Top level of the wall-follow drive controller: channels, history chain and config registers.
//
// Usage:
//   in_*  : one word per ADC set; in_tdata holds photo, front IR and right IR samples.
//   out_* : one word per accepted set; out_tdata holds left and right drive compare
//           values and the three filtered levels, out_tuser flags calibration.
//   cfg_* : register writes (index 0 gain, 1 forward, 2 backward, 3 stop, 4 turn
//           limit); always ready, writes to indexes beyond 4 are dropped. Write only
//           while no word is in flight.
//   Pipeline: level, reference product, error and gain product stages, then the output register.
//   Throughput is one set per cycle while out_tready does not stall; it is set by the
//   per-channel running-sum loop (add, multiply by reciprocal, subtract) in each averager.
//   Reset: history chain and running sums clear, registers take their defaults and
//   the block calibrates over the first CALIB_SAMPLES sets (stop drive, tuser high
//   for all but the last of them). No clearing pass is needed.
//   Stall: when out_tready is low the output register holds; the pipeline keeps
//   taking sets until its bubbles fill, then in_tready drops.
`default_nettype none

module wall_follow_drive_controller #(
  parameter int SAMPLE_BITS   = 10,
  parameter int WINDOW        = 20,
  parameter int CALIB_SAMPLES = 200
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  // photo_sample, front_sample, right_sample from bit 0 up, zero padded
  input  wire logic                                      in_tvalid,
  output logic                                           in_tready,
  input  wire logic [((3*SAMPLE_BITS+7)/8)*8-1:0]        in_tdata,
  // left_drive, right_drive, photo_level, front_level, right_level from bit 0 up
  output logic                                           out_tvalid,
  input  wire logic                                      out_tready,
  output logic [wfdc_pkg::OUT_DATA_W-1:0]                out_tdata,
  // calibrating
  output logic                                           out_tuser,
  input  wire logic                                      cfg_valid,
  output logic                                           cfg_ready,
  input  wire wfdc_pkg::cfg_idx_t                        cfg_index,
  input  wire logic [wfdc_pkg::CFG_DATA_W-1:0]           cfg_data
);

  import wfdc_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int LVW = 3 * SB;
  localparam int H   = WINDOW - 1;
  localparam logic [SB-1:0] SMAX = '1;

  logic              accept;
  logic [SB-1:0]     photo_in;
  logic [SB-1:0]     front_inv;
  logic [SB-1:0]     right_inv;
  logic [SB-1:0]     photo_lvl;
  logic [SB-1:0]     front_lvl;
  logic [SB-1:0]     right_lvl;
  logic [LVW-1:0]    tap [WINDOW];
  calib_info_t       info;
  cfg_t              cfg_r;
  logic [PWM_W-1:0]     drv_left;
  logic [PWM_W-1:0]     drv_right;
  logic [LVL_OUT_W-1:0] lvl_photo;
  logic [LVL_OUT_W-1:0] lvl_front;
  logic [LVL_OUT_W-1:0] lvl_right;
  logic                 calib;

  assign accept    = in_tvalid && in_tready;
  // IR samples read high for far walls: invert them to full scale minus sample
  assign photo_in  = in_tdata[0 +: SB];
  assign front_inv = SMAX - in_tdata[SB +: SB];
  assign right_inv = SMAX - in_tdata[2*SB +: SB];

  // the new level set enters the head of the chain
  assign tap[0] = {right_lvl, front_lvl, photo_lvl};

  // history chain: one cell per past level set, advance on every accepted word
  for (genvar k = 0; k < H; k++) begin : g_hist
    wfdc_cell #(.WIDTH(LVW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .d        (tap[k]),
      .q        (tap[k+1])
    );
  end

  wfdc_avg #(.SAMPLE_BITS(SB), .WINDOW(WINDOW)) u_avg_photo (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .sample (photo_in),
    .oldest (tap[H][0 +: SB]),
    .level  (photo_lvl)
  );

  wfdc_avg #(.SAMPLE_BITS(SB), .WINDOW(WINDOW)) u_avg_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .sample (front_inv),
    .oldest (tap[H][SB +: SB]),
    .level  (front_lvl)
  );

  wfdc_avg #(.SAMPLE_BITS(SB), .WINDOW(WINDOW)) u_avg_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .sample (right_inv),
    .oldest (tap[H][2*SB +: SB]),
    .level  (right_lvl)
  );

  // calibration runs on the raw inverted right sample, not on its level
  wfdc_calib #(.SAMPLE_BITS(SB), .CALIB_SAMPLES(CALIB_SAMPLES)) u_calib (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (accept),
    .right_raw (right_inv),
    .info      (info)
  );

  wfdc_drive #(.SAMPLE_BITS(SB), .CALIB_SAMPLES(CALIB_SAMPLES)) u_drive (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_lvl    (tap[0]),
    .in_info   (info),
    .cfg       (cfg_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .drv_left  (drv_left),
    .drv_right (drv_right),
    .lvl_photo (lvl_photo),
    .lvl_front (lvl_front),
    .lvl_right (lvl_right),
    .calib     (calib)
  );

  assign out_tdata = {{(OUT_DATA_W - 2*PWM_W - 3*LVL_OUT_W){1'b0}},
                      lvl_right, lvl_front, lvl_photo, drv_right, drv_left};
  assign out_tuser = calib;

  // configuration registers: take every write, drop unknown indexes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_q12 <= GAIN_RST;
      cfg_r.cmp_fwd  <= FORWARD_RST;
      cfg_r.cmp_bwd  <= BACKWARD_RST;
      cfg_r.cmp_halt <= STOP_RST;
      cfg_r.turn_cap <= TURN_CAP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        IDX_GAIN:     cfg_r.gain_q12 <= cfg_data[GAIN_W-1:0];
        IDX_FORWARD:  cfg_r.cmp_fwd  <= cfg_data[PWM_W-1:0];
        IDX_BACKWARD: cfg_r.cmp_bwd  <= cfg_data[PWM_W-1:0];
        IDX_STOP:     cfg_r.cmp_halt <= cfg_data[PWM_W-1:0];
        IDX_TURN_CAP: cfg_r.turn_cap <= cfg_data[TURN_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/wfdc_cell.sv -----
// One history cell: holds a set of past levels and hands it on at each accepted word.
`default_nettype none

module wfdc_cell #(
  parameter int WIDTH = 30
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             shift_en,
  input  wire logic [WIDTH-1:0] d,
  output logic      [WIDTH-1:0] q
);

  logic [WIDTH-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- design/wfdc_avg.sv -----
// Recursive average of one channel: running history sum and reciprocal divide.
`default_nettype none

module wfdc_avg #(
  parameter int SAMPLE_BITS = 10,
  parameter int WINDOW      = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [SAMPLE_BITS-1:0] oldest,
  output logic      [SAMPLE_BITS-1:0] level
);

  localparam int LW = $clog2(WINDOW);
  localparam int NW = SAMPLE_BITS + LW;
  localparam int SH = NW + LW;
  localparam int MW = NW + 2;
  localparam int PW = NW + MW;
  // round-up reciprocal: exact floor division for any NW-bit numerator
  localparam logic [63:0] RECIP64 =
    ((64'd1 << SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];
  localparam logic [63:0] SUM_MAX64 =
    64'(WINDOW - 1) * ((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [NW-1:0] SUM_MAX = SUM_MAX64[NW-1:0];

  logic [NW-1:0] hist_sum_r;
  logic [NW-1:0] hist_sum_nxt;
  logic [NW-1:0] numer;
  logic [PW-1:0] prod;

  always_comb begin
    numer        = NW'(sample) + hist_sum_r;
    prod         = {{MW{1'b0}}, numer} * {{NW{1'b0}}, RECIP};
    level        = prod[SH +: SAMPLE_BITS];
    // add the new level, drop the one leaving the last cell
    hist_sum_nxt = hist_sum_r + NW'(level) - NW'(oldest);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_sum_r <= '0;
    end else if (en) begin
      hist_sum_r <= hist_sum_nxt;
    end
  end

  a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hist_sum_r <= SUM_MAX)
    else $error("history sum beyond full window");

endmodule

`default_nettype wire

// ----- design/wfdc_calib.sv -----
// Start-up calibration: counts items and sums inverted right samples.
`default_nettype none

module wfdc_calib
  import wfdc_pkg::calib_info_t;
#(
  parameter int SAMPLE_BITS   = 10,
  parameter int CALIB_SAMPLES = 200
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [SAMPLE_BITS-1:0] right_raw,
  output calib_info_t                 info
);

  import wfdc_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_END = COUNT_W'(CALIB_SAMPLES);

  logic               active_r;
  logic [COUNT_W-1:0] count_r;
  logic [CALIB_W-1:0] sum_r;
  logic [COUNT_W-1:0] count_inc;
  logic [CALIB_W-1:0] sum_inc;
  logic               hit;

  always_comb begin
    count_inc    = count_r + COUNT_W'(1);
    sum_inc      = ((count_r == '0) ? '0 : sum_r) + CALIB_W'(right_raw);
    hit          = (count_inc == COUNT_END);
    info.stopped = active_r && !hit;
    info.last    = active_r && hit;
    info.sum     = sum_inc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b1;
      count_r  <= '0;
      sum_r    <= '0;
    end else if (en && active_r) begin
      count_r  <= hit ? '0 : count_inc;
      sum_r    <= sum_inc;
      active_r <= !hit;
    end
  end

  a_no_reentry: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |=> !active_r)
    else $error("calibration restarted without reset");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (count_r < COUNT_END))
    else $error("calibration count ran past its end");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (en && info.last) |=> !active_r)
    else $error("last calibration item did not end calibration");

endmodule

`default_nettype wire

// ----- design/wfdc_drive.sv -----
// Steering pipeline: reference divide, error times gain, turn limit and drive clamp.
`default_nettype none

module wfdc_drive #(
  parameter int SAMPLE_BITS   = 10,
  parameter int CALIB_SAMPLES = 200
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [3*SAMPLE_BITS-1:0]         in_lvl,
  input  wfdc_pkg::calib_info_t                 in_info,
  input  wfdc_pkg::cfg_t                        cfg,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [wfdc_pkg::PWM_W-1:0]            drv_left,
  output logic [wfdc_pkg::PWM_W-1:0]            drv_right,
  output logic [wfdc_pkg::LVL_OUT_W-1:0]        lvl_photo,
  output logic [wfdc_pkg::LVL_OUT_W-1:0]        lvl_front,
  output logic [wfdc_pkg::LVL_OUT_W-1:0]        lvl_right,
  output logic                                  calib
);

  import wfdc_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int LVW  = 3 * SB;
  localparam int CLOG = $clog2(CALIB_SAMPLES);
  localparam int RSH  = 26 + CLOG;
  localparam int RMW  = 28;
  localparam int RPW  = CALIB_W + RMW;
  localparam logic [63:0] RM64 =
    ((64'd1 << RSH) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES);
  localparam logic [RMW-1:0] RM = RM64[RMW-1:0];
  localparam int DW   = ((SB + 8 > CALIB_W) ? SB + 8 : CALIB_W) + 1;
  localparam int PW   = DW + GAIN_W + 1;
  localparam int TW   = PW - TURN_FRAC;

  function automatic logic [PWM_W-1:0] clamp_drv(
    input logic signed [DRV_W-1:0] v,
    input logic [PWM_W-1:0]        hi,
    input logic [PWM_W-1:0]        lo
  );
    logic signed [DRV_W-1:0] x;
    x = v;
    if (x > $signed({2'b00, hi})) x = $signed({2'b00, hi});
    if (x < $signed({2'b00, lo})) x = $signed({2'b00, lo});
    return x[PWM_W-1:0];
  endfunction

  // stage 1: levels and calibration outcome
  logic               v1_r;
  logic [LVW-1:0]     lv1_r;
  calib_info_t        info1_r;
  // stage 2: reference product
  logic               v2_r;
  logic [LVW-1:0]     lv2_r;
  logic               stop2_r;
  logic               last2_r;
  logic [RPW-1:0]     rprod2_r;
  // stage 3: signed error
  logic               v3_r;
  logic [LVW-1:0]     lv3_r;
  logic               stop3_r;
  logic signed [DW-1:0] diff3_r;
  // stage 4: gain product
  logic               v4_r;
  logic [LVW-1:0]     lv4_r;
  logic               stop4_r;
  logic signed [PW-1:0] prod4_r;
  // output register
  logic               vo_r;
  logic [PWM_W-1:0]   left_o_r;
  logic [PWM_W-1:0]   right_o_r;
  logic [LVW-1:0]     lvo_r;
  logic               calib_o_r;

  logic [CALIB_W-1:0] reference_r;

  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic ref_load;
  logic [CALIB_W-1:0] ref_sel;
  logic [RPW-1:0]     rprod_nxt;
  logic signed [DW-1:0] diff_nxt;
  logic signed [PW-1:0] prod_nxt;
  logic signed [TW-1:0] t_quo;
  logic signed [TW-1:0] t_max;
  logic signed [TW-1:0] turn_lim;
  logic signed [DRV_W-1:0] turn_d;
  logic signed [DRV_W-1:0] fwd_s;
  logic signed [DRV_W-1:0] stop_s;
  logic signed [DRV_W-1:0] left_raw;
  logic signed [DRV_W-1:0] right_raw;

  always_comb begin
    rdy_o    = !vo_r || out_ready;
    rdy4     = !v4_r || rdy_o;
    rdy3     = !v3_r || rdy4;
    rdy2     = !v2_r || rdy3;
    rdy1     = !v1_r || rdy2;
    in_ready = rdy1;

    rprod_nxt = RPW'(info1_r.sum) * RPW'(RM);

    ref_load = rdy3 && v2_r && last2_r;
    ref_sel  = last2_r ? rprod2_r[(RSH - 8) +: CALIB_W] : reference_r;
    diff_nxt = $signed({{(DW - CALIB_W){1'b0}}, ref_sel})
             - $signed({{(DW - SB - 8){1'b0}}, lv2_r[2*SB +: SB], 8'b0});

    prod_nxt = PW'($signed({1'b0, cfg.gain_q12})) * PW'(diff3_r);

    // quotient by 2^20 truncated toward zero
    t_quo = $signed(prod4_r[PW-1:TURN_FRAC])
          + TW'(prod4_r[PW-1] && (prod4_r[TURN_FRAC-1:0] != '0));
    t_max = $signed({{(TW - TURN_W){1'b0}}, cfg.turn_cap});
    if (t_quo > t_max) begin
      turn_lim = t_max;
    end else if (t_quo < -t_max) begin
      turn_lim = -t_max;
    end else begin
      turn_lim = t_quo;
    end
    turn_d = turn_lim[DRV_W-1:0];

    fwd_s  = $signed({2'b00, cfg.cmp_fwd});
    stop_s = $signed({2'b00, cfg.cmp_halt});
    left_raw  = stop4_r ? stop_s : fwd_s - turn_d;
    right_raw = stop4_r ? stop_s : fwd_s + turn_d;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vo_r        <= 1'b0;
      reference_r <= '0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy_o) vo_r <= v4_r;
      if (ref_load) reference_r <= ref_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      lv1_r   <= in_lvl;
      info1_r <= in_info;
    end
    if (rdy2) begin
      lv2_r    <= lv1_r;
      stop2_r  <= info1_r.stopped;
      last2_r  <= info1_r.last;
      rprod2_r <= rprod_nxt;
    end
    if (rdy3) begin
      lv3_r   <= lv2_r;
      stop3_r <= stop2_r;
      diff3_r <= diff_nxt;
    end
    if (rdy4) begin
      lv4_r   <= lv3_r;
      stop4_r <= stop3_r;
      prod4_r <= prod_nxt;
    end
    if (rdy_o) begin
      lvo_r     <= lv4_r;
      calib_o_r <= stop4_r;
      left_o_r  <= clamp_drv(left_raw, cfg.cmp_fwd, cfg.cmp_bwd);
      right_o_r <= clamp_drv(right_raw, cfg.cmp_fwd, cfg.cmp_bwd);
    end
  end

  assign out_valid = vo_r;
  assign drv_left  = left_o_r;
  assign drv_right = right_o_r;
  assign lvl_photo = LVL_OUT_W'(lvo_r[0 +: SB]);
  assign lvl_front = LVL_OUT_W'(lvo_r[SB +: SB]);
  assign lvl_right = LVL_OUT_W'(lvo_r[2*SB +: SB]);
  assign calib     = calib_o_r;

  a_ref_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(reference_r)) |-> $past(ref_load))
    else $error("reference changed outside the last calibration item");

  a_stopped_even: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && calib_o_r) |-> (left_o_r == right_o_r))
    else $error("unequal drives while stopped");

endmodule

`default_nettype wire

// ----- tb/tb_wall_follow_drive_controller.sv -----
// Self-checking testbench for the wall-follow drive controller stream block.
module tb_wall_follow_drive_controller;
  timeunit 1ns;
  timeprecision 1ps;

  import wfdc_pkg::*;

  // Block geometry as instantiated (default parameters)
  localparam int          AVG_LEN        = 20;    // averaging window of each level
  localparam int          HIST_LEN       = AVG_LEN - 1;
  localparam int          SETTLE_SETS    = 200;   // sets averaged into the wall reference
  localparam int          IN_DATA_W      = 32;
  localparam logic [9:0]  FULL_SCALE     = 10'h3FF;
  localparam longint      TURN_SCALE     = 64'd1 << TURN_FRAC;
  localparam int          TAIL_CYCLES    = 10;    // well over the pipeline latency
  localparam int          WATCHDOG_LIMIT = 1000;  // cycles without any handshake
  localparam int          LONG_HOLD      = 120;

  // Register indexes that map to nothing; writes there must be dropped
  localparam cfg_idx_t IDX_UNMAPPED_FIRST = 3'd5;
  localparam cfg_idx_t IDX_UNMAPPED_LAST  = 3'd7;

  typedef enum int {CH_PHOTO, CH_FRONT, CH_RIGHT} sensor_ch_t;

  // One result word, field by field
  typedef struct {
    logic [9:0] left_drive;
    logic [9:0] right_drive;
    logic [9:0] photo_level;
    logic [9:0] front_level;
    logic [9:0] right_level;
    logic       calibrating;
  } drive_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // photo, front, right samples from bit 0 up
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // left, right drive, photo, front, right level
  logic                  out_tuser;   // calibrating
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: filter histories, wall reference gathering and register copy
  logic [9:0]          history [3][HIST_LEN];
  logic                settling;
  logic [COUNT_W-1:0]  settle_count;
  logic [CALIB_W-1:0]  settle_sum;
  logic [CALIB_W-1:0]  ref_right_q8;
  cfg_t                regs;

  drive_word_t pending_drives[$];   // expected result words, oldest first
  int          error_count = 0;
  int          quiet_cycles = 0;

  // Knobs shared by the stimulus, the receiver and the test tasks
  bit sender_gaps     = 1'b1;
  bit receiver_stalls = 1'b1;
  int hold_request    = 0;

  wall_follow_drive_controller DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Recursive average: new sample plus the last HIST_LEN levels, floored; push level
  function automatic logic [9:0] smooth_level(sensor_ch_t ch, logic [9:0] sample);
    int acc;
    int k;
    acc = sample;
    for (k = 0; k < HIST_LEN; k++) acc += history[ch][k];
    acc = acc / AVG_LEN;
    for (k = HIST_LEN - 1; k > 0; k--) history[ch][k] = history[ch][k-1];
    history[ch][0] = acc[9:0];
    return acc[9:0];
  endfunction

  // Upper clamp first, then lower, so backward wins when it lies above forward
  function automatic longint clamp_to_band(longint v);
    if (v > longint'(regs.cmp_fwd)) v = longint'(regs.cmp_fwd);
    if (v < longint'(regs.cmp_bwd)) v = longint'(regs.cmp_bwd);
    return v;
  endfunction

  function automatic drive_word_t predict_drive(logic [9:0] photo, logic [9:0] front,
                                                logic [9:0] right);
    drive_word_t w;
    logic [9:0]  right_inv;
    logic        stopped;
    longint      diff, turn, left_v, right_v, scaled;
    right_inv     = FULL_SCALE - right;
    w.photo_level = smooth_level(CH_PHOTO, photo);
    w.front_level = smooth_level(CH_FRONT, FULL_SCALE - front);
    w.right_level = smooth_level(CH_RIGHT, right_inv);
    stopped = 1'b0;
    if (settling) begin
      stopped = 1'b1;
      if (settle_count == 0) settle_sum = '0;
      settle_count = settle_count + 1'b1;
      settle_sum   = settle_sum + right_inv;
      // the closing set already drives
      if (settle_count == SETTLE_SETS) begin
        scaled       = longint'(settle_sum) * 256 / SETTLE_SETS;
        ref_right_q8 = scaled[CALIB_W-1:0];
        settle_count = '0;
        settling     = 1'b0;
        stopped      = 1'b0;
      end
    end
    if (stopped) begin
      left_v  = longint'(regs.cmp_halt);
      right_v = longint'(regs.cmp_halt);
    end else begin
      diff = longint'(ref_right_q8) - longint'(w.right_level) * 256;
      turn = longint'(regs.gain_q12) * diff / TURN_SCALE;   // truncates toward zero
      if (turn >  longint'(regs.turn_cap)) turn =  longint'(regs.turn_cap);
      if (turn < -longint'(regs.turn_cap)) turn = -longint'(regs.turn_cap);
      left_v  = longint'(regs.cmp_fwd) - turn;
      right_v = longint'(regs.cmp_fwd) + turn;
    end
    left_v        = clamp_to_band(left_v);
    right_v       = clamp_to_band(right_v);
    w.left_drive  = left_v[9:0];
    w.right_drive = right_v[9:0];
    w.calibrating = stopped;
    return w;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: check result words, mirror register writes, predict accepted sets,
  // and keep the watchdog. Everything is sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    drive_word_t want;
    bit          moved;
    int          ch, k;
    moved = 1'b0;
    if (!rst_n) begin
      // mirror the synchronous reset of the block
      for (ch = 0; ch < 3; ch++)
        for (k = 0; k < HIST_LEN; k++) history[ch][k] = '0;
      settling      = 1'b1;
      settle_count  = '0;
      settle_sum    = '0;
      ref_right_q8  = '0;
      regs.gain_q12 = GAIN_RST;
      regs.cmp_fwd  = FORWARD_RST;
      regs.cmp_bwd  = BACKWARD_RST;
      regs.cmp_halt = STOP_RST;
      regs.turn_cap = TURN_CAP_RST;
    end else begin
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (pending_drives.size() == 0) begin
          $display("%0t: result word with nothing pending, expected none, actual %h",
                   $time, out_tdata);
          error_count++;
        end else begin
          want = pending_drives.pop_front();
          check_field("left_drive",  want.left_drive,  out_tdata[9:0]);
          check_field("right_drive", want.right_drive, out_tdata[19:10]);
          check_field("photo_level", want.photo_level, out_tdata[29:20]);
          check_field("front_level", want.front_level, out_tdata[39:30]);
          check_field("right_level", want.right_level, out_tdata[49:40]);
          check_field("calibrating", want.calibrating, out_tuser);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        // narrow registers keep only their low bits; unmapped indexes change nothing
        case (cfg_index)
          IDX_GAIN:     regs.gain_q12 = cfg_data[GAIN_W-1:0];
          IDX_FORWARD:  regs.cmp_fwd  = cfg_data[PWM_W-1:0];
          IDX_BACKWARD: regs.cmp_bwd  = cfg_data[PWM_W-1:0];
          IDX_STOP:     regs.cmp_halt = cfg_data[PWM_W-1:0];
          IDX_TURN_CAP: regs.turn_cap = cfg_data[TURN_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        pending_drives.push_back(predict_drive(in_tdata[9:0], in_tdata[19:10],
                                               in_tdata[29:20]));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: drive out_tready at the falling edge. Stall in random bursts, or
  // hold off for a long stretch when a test asks for it.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        out_tready = 1'b0;
        hold--;
      end else if (receiver_stalls && $urandom_range(0, 7) == 0) begin
        out_tready = 1'b0;
        hold       = $urandom_range(1, 15) - 1;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers. Each is entered at a falling edge and returns at one.
  // ---------------------------------------------------------------------------

  // Offer one sample set and hold it until the block takes the word
  task automatic send_sample(logic [9:0] photo, logic [9:0] front, logic [9:0] right);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    in_tdata  = {2'b00, right, front, photo};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop the input and wait for every expected word to come back
  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (pending_drives.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(logic [11:0] gain, logic [11:0] fwd, logic [11:0] bwd,
                          logic [11:0] stop, logic [11:0] turn_lim);
    write_reg(IDX_GAIN, gain);
    write_reg(IDX_FORWARD, fwd);
    write_reg(IDX_BACKWARD, bwd);
    write_reg(IDX_STOP, stop);
    write_reg(IDX_TURN_CAP, turn_lim);
  endtask

  function automatic logic [9:0] jitter(int base, int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0)    v = 0;
    if (v > 1023) v = 1023;
    return v[9:0];
  endfunction

  // Drive the car along walls: runs of sets that hover around a target so the
  // levels actually settle. Most runs sit close to the wall reference (small,
  // unsaturated turns), some aim anywhere, a few are pure noise.
  task automatic send_segments(int total);
    int sent, run, mode, centre, photo_base, front_base, i;
    sent = 0;
    while (sent < total) begin
      run = $urandom_range(5, 25);
      if (run > total - sent) run = total - sent;
      mode = $urandom_range(0, 9);
      if (mode < 6) centre = 1023 - int'(ref_right_q8[17:8]) + int'($urandom_range(0, 60)) - 30;
      else          centre = $urandom_range(0, 1023);
      photo_base = $urandom_range(0, 1023);
      front_base = $urandom_range(0, 1023);
      for (i = 0; i < run; i++) begin
        if (mode == 9)
          send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                      10'($urandom_range(0, 1023)));
        else
          send_sample(jitter(photo_base, 40), jitter(front_base, 40), jitter(centre, 8));
      end
      sent += run;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // First 200 sets after reset: car stopped while the reference builds up.
  // Vary the stop value against the drive band, then cross into driving on
  // the closing set with the default registers.
  task automatic test_calibration();
    send_sample('0, '0, '0);
    send_sample(FULL_SCALE, FULL_SCALE, FULL_SCALE);
    send_sample(10'h2AA, 10'h155, 10'h2AA);
    send_sample(10'h155, 10'h2AA, 10'h155);
    send_segments(56);
    wait_drained();
    // stop value above forward: stopped drives get clamped down to forward
    set_regs(GAIN_RST, 12'd600, 12'd100, 12'd800, 12'(TURN_CAP_RST));
    send_segments(60);
    wait_drained();
    // backward above forward while stopped: both drives sit at backward
    set_regs(GAIN_RST, 12'd200, 12'd650, 12'd0, 12'(TURN_CAP_RST));
    send_segments(60);
    wait_drained();
    // last sets of calibration and the first driven ones
    set_regs(GAIN_RST, 12'(FORWARD_RST), 12'(BACKWARD_RST), 12'(STOP_RST),
             12'(TURN_CAP_RST));
    send_segments(25);
    wait_drained();
  endtask

  // Field extremes and every register corner once the car drives
  task automatic test_directed_corners();
    int i;
    send_sample('0, '0, '0);
    send_sample(FULL_SCALE, FULL_SCALE, FULL_SCALE);
    send_sample(10'h2AA, 10'h155, 10'h2AA);
    send_sample(10'h155, 10'h2AA, 10'h155);
    wait_drained();
    // full gain and a wide turn limit: hard turns both ways
    set_regs(12'hFFF, 12'd800, 12'd0, 12'd400, 12'd400);
    for (i = 0; i < 3; i++) send_sample('0, FULL_SCALE, '0);
    for (i = 0; i < 3; i++) send_sample(FULL_SCALE, '0, FULL_SCALE);
    wait_drained();
    // upper data bits must be dropped: turn limit lands on zero, band widest
    write_reg(IDX_TURN_CAP, 12'hE00);
    write_reg(IDX_FORWARD, 12'hFFF);
    write_reg(IDX_BACKWARD, 12'hC00);
    write_reg(IDX_STOP, 12'hFFF);
    for (i = 0; i < 3; i++) send_sample(10'h3FF, 10'h000, 10'h000);
    wait_drained();
    // zero gain: no turn at all
    set_regs(12'd0, 12'(FORWARD_RST), 12'(BACKWARD_RST), 12'(STOP_RST), 12'h1FF);
    send_sample('0, '0, FULL_SCALE);
    send_sample('0, '0, '0);
    wait_drained();
    // backward above forward: both drives pinned at backward
    set_regs(12'hFFF, 12'd100, 12'd700, 12'(STOP_RST), 12'd400);
    for (i = 0; i < 4; i++) send_sample(10'h200, 10'h200, (i % 2) ? FULL_SCALE : 10'h000);
    wait_drained();
    // unmapped indexes: writes land nowhere
    for (i = IDX_UNMAPPED_FIRST; i <= IDX_UNMAPPED_LAST; i++)
      write_reg(cfg_idx_t'(i), 12'hFFF);
    for (i = 0; i < 3; i++) send_sample(10'h100, 10'h300, 10'h1FF);
    wait_drained();
  endtask

  // Random wall following under several register settings
  task automatic test_steering();
    int          phase;
    logic [11:0] fwd;
    for (phase = 0; phase < 4; phase++) begin
      if (phase == 1) begin
        set_regs(12'hFFF, 12'd800, 12'd0, 12'd800, 12'd400);
      end else begin
        fwd = 12'($urandom_range(0, 800));
        set_regs(12'($urandom_range(0, 4095)), fwd,
                 12'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 800)
                                                 : $urandom_range(0, fwd)),
                 12'($urandom_range(0, 800)), 12'($urandom_range(0, 400)));
      end
      send_segments(40);
      wait_drained();
    end
  endtask

  // Hold the receiver off long enough that the pipeline fills and in_tready drops
  task automatic test_backpressure();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    hold_request    = LONG_HOLD;
    send_segments(40);
    wait_drained();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // One set at a time: wait for its word before offering the next
  task automatic test_paced_sender();
    int i;
    for (i = 0; i < 10; i++) begin
      send_sample(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                  10'($urandom_range(0, 1023)));
      wait_drained();
    end
  endtask

  // Back-to-back words on both sides to close the run
  task automatic test_full_rate();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    set_regs(GAIN_RST, 12'(FORWARD_RST), 12'(BACKWARD_RST), 12'(STOP_RST), 12'd50);
    send_segments(30);
    wait_drained();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = IDX_GAIN;
    cfg_data   = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    test_calibration();
    test_directed_corners();
    test_steering();
    test_backpressure();
    test_paced_sender();
    test_full_rate();

    // let anything late show up before judging
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    error_count += pending_drives.size();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
